// ===== rtl/core/sequence_duplicate_filter_top_macros.svh =====
// Assertion macros for the sequence duplicate filter.
// Included by sequence_duplicate_filter_top; needs clk and rst_n in scope.
`ifndef SEQUENCE_DUPLICATE_FILTER_TOP_MACROS_SVH
`define SEQUENCE_DUPLICATE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sdf_pkg.sv =====
// Shared constants and types for the sequence duplicate filter.
// No dependencies; used by all modules in rtl/core.
package sdf_pkg;

    localparam int SEQ_W          = 16;
    localparam int WORD_BITS      = 32;
    localparam int BIT_IDX_W      = 5;
    localparam int WORD_SEL_W     = SEQ_W - BIT_IDX_W;
    localparam int BLOCK_COUNT    = 4;
    localparam int BLOCK_W        = 2;
    localparam int WORD_COUNT_DEF = 2048;
    localparam int BLOCK_SIZE_DEF = 16384;

    // Map port control: one access per cycle, read data in the cycle after the read.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ram_ctl_t;

endpackage

// ===== rtl/core/sdf_index.sv =====
// Index unit: word index and block number of a sequence number.
// Uses sdf_pkg. Two register stages of constant reciprocal multiplies.
module sdf_index #(
    parameter int WORD_COUNT = sdf_pkg::WORD_COUNT_DEF,
    parameter int BLOCK_SIZE = sdf_pkg::BLOCK_SIZE_DEF,
    parameter int AW         = $clog2(WORD_COUNT)
) (
    input  logic                             clk,
    input  logic [sdf_pkg::SEQ_W-1:0]        seq,
    output logic [sdf_pkg::BLOCK_W-1:0]      block,
    output logic [AW-1:0]                    word_index
);

    localparam int XW  = sdf_pkg::WORD_SEL_W;
    localparam int SB  = sdf_pkg::SEQ_W + $clog2(BLOCK_SIZE);
    localparam longint unsigned MB =
        ((64'd1 << SB) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE);
    localparam int MBW = $clog2(MB + 64'd1);
    localparam int PBW = sdf_pkg::SEQ_W + MBW;

    logic [XW-1:0]                 word_sel;
    logic [PBW-1:0]                prod_b_reg;
    logic [sdf_pkg::BLOCK_W-1:0]   block_reg;

    assign word_sel = seq[sdf_pkg::SEQ_W-1:sdf_pkg::BIT_IDX_W];

    // block = (seq / BLOCK_SIZE) mod 4, exact by rounded-up reciprocal
    always_ff @(posedge clk)
    begin
        prod_b_reg <= PBW'(seq) * PBW'(MB);
        block_reg  <= sdf_pkg::BLOCK_W'(prod_b_reg >> SB);
    end

    assign block = block_reg;

    generate
        if (WORD_COUNT >= (1 << XW))
        begin : g_direct
            assign word_index = AW'(word_sel);
        end
        else
        begin : g_reduce
            localparam int SW  = XW + AW;
            localparam int MW  = ((1 << SW) + WORD_COUNT - 1) / WORD_COUNT;
            localparam int MWW = $clog2(MW + 1);
            localparam int PWW = XW + MWW;

            logic [PWW-1:0] prod_w_reg;
            logic [XW-1:0]  quot_w;
            logic [XW-1:0]  base_reg;

            assign quot_w = XW'(prod_w_reg >> SW);

            always_ff @(posedge clk)
            begin
                prod_w_reg <= PWW'(word_sel) * PWW'(MW);
                base_reg   <= XW'(quot_w * XW'(WORD_COUNT));
            end

            assign word_index = AW'(word_sel - base_reg);
        end
    endgenerate

endmodule

// ===== rtl/core/sdf_map_ram.sv =====
// Seen-map storage: WORD_COUNT words of 32 bits, one port, registered read.
// Uses sdf_pkg for the port control struct.
module sdf_map_ram #(
    parameter int WORD_COUNT = sdf_pkg::WORD_COUNT_DEF,
    parameter int AW         = $clog2(WORD_COUNT)
) (
    input  logic                              clk,
    input  sdf_pkg::ram_ctl_t                 ctl,
    input  logic [AW-1:0]                     addr,
    input  logic [sdf_pkg::WORD_BITS-1:0]     wdata,
    output logic [sdf_pkg::WORD_BITS-1:0]     rdata
);

    logic [sdf_pkg::WORD_BITS-1:0] map_mem [WORD_COUNT];
    logic [sdf_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            map_mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= map_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sequence_duplicate_filter_top.sv =====
// Sequence duplicate filter: anti-replay bitmap window over 16-bit numbers.
// Uses sdf_pkg, sdf_index, sdf_map_ram and the assertion macro header.
//
// Usage:
//   Input channel in_valid/in_stall carries one sequence_number per
//   transaction. Output channel out_valid/out_stall returns one result per
//   input: is_new (first sighting, now recorded) and window_moved (the oldest
//   block of the map was cleared and the window advanced one block).
// Timing:
//   After the accepting edge the number passes two index stages (constant
//   reciprocal multiplies), map read, then check and write back, and the
//   result is registered. A new transaction is taken only back in idle.
//   When the window moves, the BLOCK_SIZE/32 words of the oldest block are
//   cleared first (one map word per cycle through the single map port),
//   then the word is read again. One item is in work at a time.
// Reset:
//   rst_n clears the control state, then a clearing pass writes zero to all
//   WORD_COUNT map words, one per cycle; in_stall stays high during the pass.
// Stall:
//   The result sits in an output register. The block takes a new input while
//   that result waits; a later result holds in the check step until the
//   output register is free.
`include "sequence_duplicate_filter_top_macros.svh"

module sequence_duplicate_filter_top #(
    parameter int WORD_COUNT = sdf_pkg::WORD_COUNT_DEF,
    parameter int BLOCK_SIZE = sdf_pkg::BLOCK_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sdf_pkg::SEQ_W-1:0]     sequence_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          is_new,
    output logic                          window_moved
);

    localparam int AW  = $clog2(WORD_COUNT);
    localparam int WPB = BLOCK_SIZE / sdf_pkg::WORD_BITS;
    localparam int CW  = $clog2(WPB);
    localparam int BW  = sdf_pkg::BLOCK_W;
    localparam int DW  = sdf_pkg::WORD_BITS;

    // First map word of each block, wrapped into the map
    localparam logic [AW-1:0] BLOCK_START [sdf_pkg::BLOCK_COUNT] = '{
        AW'(0),
        AW'(WPB % WORD_COUNT),
        AW'((2 * WPB) % WORD_COUNT),
        AW'((3 * WPB) % WORD_COUNT)
    };

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_CLEAR = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  clr_addr_reg, clr_addr_next;
    logic [CW-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic [BW-1:0]                  older_reg, older_next;
    logic [BW-1:0]                  newer_reg, newer_next;
    logic                           moved_reg, moved_next;
    logic                           out_valid_reg, out_valid_next;
    logic [sdf_pkg::SEQ_W-1:0]      seq_reg;
    logic                           is_new_reg, is_new_next;
    logic                           window_moved_reg, window_moved_next;

    logic                           accept;
    logic                           out_free;
    logic                           result_load;
    logic                           clear_last;
    logic                           init_last;
    logic [AW-1:0]                  clr_addr_inc;
    logic [BW-1:0]                  seq_block;
    logic [AW-1:0]                  word_index;
    logic                           bit_seen;
    logic                           need_move;
    sdf_pkg::ram_ctl_t              ram_ctl;
    logic [AW-1:0]                  ram_addr;
    logic [DW-1:0]                  ram_wdata;
    logic [DW-1:0]                  ram_rdata;

    sdf_index #(
        .WORD_COUNT (WORD_COUNT),
        .BLOCK_SIZE (BLOCK_SIZE),
        .AW         (AW)
    ) u_index (
        .clk        (clk),
        .seq        (seq_reg),
        .block      (seq_block),
        .word_index (word_index)
    );

    sdf_map_ram #(
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW)
    ) u_map (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign clr_addr_inc = (clr_addr_reg == AW'(WORD_COUNT - 1)) ? '0 : clr_addr_reg + 1'b1;
    assign clear_last   = (state_reg == ST_CLEAR) && (clr_cnt_reg == CW'(WPB - 1));
    assign init_last    = (state_reg == ST_INIT) && (clr_addr_reg == AW'(WORD_COUNT - 1));

    // Map word and block test for the held number
    assign bit_seen  = ram_rdata[seq_reg[sdf_pkg::BIT_IDX_W-1:0]];
    assign need_move = (seq_block != older_reg) && (seq_block != newer_reg) &&
                       (seq_block != BW'(newer_reg + 2'd2));

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        clr_cnt_next      = clr_cnt_reg;
        older_next        = older_reg;
        newer_next        = newer_reg;
        moved_next        = moved_reg;
        is_new_next       = is_new_reg;
        window_moved_next = window_moved_reg;
        result_load       = 1'b0;
        ram_ctl           = '0;
        ram_addr          = word_index;
        ram_wdata         = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Sweep zeros through the whole map after reset
                ram_ctl.wr_en = 1'b1;
                ram_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_inc;
                if (init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    moved_next = 1'b0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_ctl.rd_en = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (!moved_reg && bit_seen)
                begin
                    // Duplicate: report and change nothing
                    if (out_free)
                    begin
                        result_load       = 1'b1;
                        is_new_next       = 1'b0;
                        window_moved_next = 1'b0;
                        state_next        = ST_IDLE;
                    end
                end
                else if (!moved_reg && need_move)
                begin
                    clr_addr_next = BLOCK_START[older_reg];
                    clr_cnt_next  = '0;
                    moved_next    = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else
                begin
                    // Record the number and report it as new
                    if (out_free)
                    begin
                        ram_ctl.wr_en     = 1'b1;
                        ram_wdata         = ram_rdata |
                                            (DW'(1) << seq_reg[sdf_pkg::BIT_IDX_W-1:0]);
                        result_load       = 1'b1;
                        is_new_next       = 1'b1;
                        window_moved_next = moved_reg;
                        state_next        = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                // Zero the oldest block, then re-read the target word
                ram_ctl.wr_en = 1'b1;
                ram_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_inc;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clear_last)
                begin
                    older_next = newer_reg;
                    newer_next = newer_reg + 2'd1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_addr_reg  <= '0;
            clr_cnt_reg   <= '0;
            older_reg     <= BW'(0);
            newer_reg     <= BW'(1);
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_cnt_reg   <= clr_cnt_next;
            older_reg     <= older_next;
            newer_reg     <= newer_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold the number during work, hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg <= sequence_number;
        end
        is_new_reg       <= is_new_next;
        window_moved_reg <= window_moved_next;
    end

    assign out_valid    = out_valid_reg;
    assign is_new       = is_new_reg;
    assign window_moved = window_moved_reg;

    `SDF_ASSERT_NOW(a_moved_only_when_new, out_valid_reg && window_moved_reg, is_new_reg, "window move reported on a duplicate")
    `SDF_ASSERT_NOW(a_window_adjacent, state_reg != ST_CLEAR, newer_reg == BW'(older_reg + 2'd1), "current blocks not adjacent")
    `SDF_ASSERT_NEXT(a_clear_then_reread, clear_last, (state_reg == ST_READ) && moved_reg, "block clear did not return to map read")

endmodule
